>>> hw/rtl/ile_pkg.sv
// Package for the indexed list engine: request and response types,
// operation and status codes, and the control word that drives the cell row.
// It depends on nothing else.
package ile_pkg;

	localparam int DATA_BITS  = 32;
	localparam int INDEX_BITS = 7;
	localparam int LEN_BITS   = 7;

	typedef enum logic [1:0] {
		REQ_INSERT = 2'd0,
		REQ_GET    = 2'd1,
		REQ_REMOVE = 2'd2,
		REQ_SET    = 2'd3
	} req_type_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		req_type_t              req_type;
		logic [INDEX_BITS-1:0]  index;
		logic [DATA_BITS-1:0]   data_in;
	} req_item_t;

	typedef struct packed {
		logic [DATA_BITS-1:0]   data_out;
		status_t                status;
		logic [LEN_BITS-1:0]    list_length;
	} rsp_item_t;

	typedef struct packed {
		logic ins;
		logic rem;
		logic wr;
	} cell_ctl_t;

endpackage

>>> hw/rtl/ile_cell.sv
// One list position of the indexed list engine: holds a single entry and
// shifts it to or from its neighbours. Depends on ile_pkg.
module ile_cell #(
	parameter int POS        = 0,
	parameter int PW         = 7,
	parameter int DATA_WIDTH = 32
) (
	input  logic                  clk,
	input  ile_pkg::cell_ctl_t    ctl,
	input  logic [PW-1:0]         idx,
	input  logic [DATA_WIDTH-1:0] word,
	input  logic [DATA_WIDTH-1:0] from_lower,
	input  logic [DATA_WIDTH-1:0] from_upper,
	output logic [DATA_WIDTH-1:0] data,
	output logic [DATA_WIDTH-1:0] hit_data
);
	import ile_pkg::*;

	localparam logic [PW-1:0] MY_POS = PW'(POS);

	logic [DATA_WIDTH-1:0] data_q;
	logic                  at_idx;
	logic                  above_idx;

	assign at_idx    = (MY_POS == idx);
	assign above_idx = (MY_POS > idx);
	assign data      = data_q;
	assign hit_data  = at_idx ? data_q : '0;

	always_ff @(posedge clk) begin
		if (ctl.ins && above_idx) begin
			data_q <= from_lower;
		end else if ((ctl.ins || ctl.wr) && at_idx) begin
			data_q <= word;
		end else if (ctl.rem && (above_idx || at_idx)) begin
			data_q <= from_upper;
		end
	end

endmodule

>>> hw/rtl/indexed_list_engine.sv
// Indexed list engine: an ordered list of up to MAX_ENTRIES words addressed by position, held
// in a row of cells, one per position. For each request every cell compares its
// position with the index and loads its own word, its lower neighbour's or its upper
// neighbour's, so insert and remove shift the whole list at once. The response is registered;
// a new request is taken in every cycle in which no response is waiting or the waiting one is
// transferred. Depends on ile_pkg and ile_cell.
module indexed_list_engine #(
	parameter int MAX_ENTRIES = 64,
	parameter int DATA_WIDTH  = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  ile_pkg::req_item_t req,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output ile_pkg::rsp_item_t rsp
);
	import ile_pkg::*;

	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int PW = (CW > INDEX_BITS) ? CW : INDEX_BITS;

	logic [CW-1:0]         cnt_q;
	logic [CW-1:0]         cnt_next;
	logic                  rsp_valid_q;
	rsp_item_t             rsp_q;
	logic                  acc;
	logic [PW-1:0]         idx_w;
	logic [PW-1:0]         cnt_w;
	logic                  full;
	status_t               st;
	cell_ctl_t             ctl;
	logic [DATA_WIDTH-1:0] word;
	logic [DATA_WIDTH-1:0] rd;
	logic [DATA_WIDTH-1:0] cell_data [MAX_ENTRIES];
	logic [DATA_WIDTH-1:0] cell_hit  [MAX_ENTRIES];

	assign req_ready = !rsp_valid_q || rsp_ready;
	assign acc       = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign idx_w = PW'(req.index);
	assign cnt_w = PW'(cnt_q);
	assign full  = (cnt_q == CW'(MAX_ENTRIES));
	assign word  = DATA_WIDTH'(req.data_in);

	always_comb begin
		if (req.req_type == REQ_INSERT) begin
			if (idx_w > cnt_w) begin
				st = ST_RANGE;
			end else if (full) begin
				st = ST_FULL;
			end else begin
				st = ST_OK;
			end
		end else if (idx_w >= cnt_w) begin
			st = ST_RANGE;
		end else begin
			st = ST_OK;
		end
	end

	always_comb begin
		ctl.ins = acc && (st == ST_OK) && (req.req_type == REQ_INSERT);
		ctl.rem = acc && (st == ST_OK) && (req.req_type == REQ_REMOVE);
		ctl.wr  = acc && (st == ST_OK) && (req.req_type == REQ_SET);
	end

	always_comb begin
		cnt_next = cnt_q;
		if (ctl.ins) begin
			cnt_next = cnt_q + CW'(1);
		end else if (ctl.rem) begin
			cnt_next = cnt_q - CW'(1);
		end
	end

	always_comb begin
		rd = '0;
		for (int k = 0; k < MAX_ENTRIES; k++) begin
			rd = rd | cell_hit[k];
		end
	end

	for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
		logic [DATA_WIDTH-1:0] lower;
		logic [DATA_WIDTH-1:0] upper;
		if (k == 0) begin : g_first
			assign lower = '0;
		end else begin : g_mid_lo
			assign lower = cell_data[k-1];
		end
		if (k == MAX_ENTRIES - 1) begin : g_last
			assign upper = '0;
		end else begin : g_mid_hi
			assign upper = cell_data[k+1];
		end
		ile_cell #(
			.POS        (k),
			.PW         (PW),
			.DATA_WIDTH (DATA_WIDTH)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.idx        (idx_w),
			.word       (word),
			.from_lower (lower),
			.from_upper (upper),
			.data       (cell_data[k]),
			.hit_data   (cell_hit[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			cnt_q <= cnt_next;
			if (acc) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			rsp_q.status      <= st;
			rsp_q.list_length <= LEN_BITS'(cnt_next);
			if (st != ST_OK) begin
				rsp_q.data_out <= '0;
			end else if (req.req_type == REQ_INSERT || req.req_type == REQ_SET) begin
				rsp_q.data_out <= DATA_BITS'(word);
			end else begin
				rsp_q.data_out <= DATA_BITS'(rd);
			end
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_ENTRIES))
		else $error("Entry count exceeds the capacity.");

	a_ins_grows: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.ins |=> cnt_q == $past(cnt_q) + CW'(1))
		else $error("A successful insert did not grow the list by one.");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.status != ST_OK) |-> rsp_q.data_out == '0)
		else $error("An error response carries non-zero data.");

	a_rsp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> rsp_valid_q)
		else $error("An accepted request produced no response.");

endmodule

>>> dv/testbench.sv
// Self-checking testbench for indexed_list_engine: directed edge cases, a fill to capacity,
// a long output hold-off and shaped random traffic, checked against a behavioural list model.
// Depends on ile_pkg and the engine RTL.
module testbench;
	import ile_pkg::*;

	localparam int LIST_CAP       = 64;
	localparam int TIMEOUT_CYCLES = 200000;

	logic      clk;
	logic      arst_n;
	logic      req_valid;
	logic      req_ready;
	req_item_t req;
	logic      rsp_valid;
	logic      rsp_ready;
	rsp_item_t rsp;

	rsp_item_t            pending_rsp [$];
	logic [DATA_BITS-1:0] list_words [LIST_CAP];
	int                   list_len;
	int                   fail_count;
	int                   cycle_count;
	bit                   sender_gaps;
	bit                   receiver_stalls;
	int                   hold_cycles;

	indexed_list_engine #(
		.MAX_ENTRIES(LIST_CAP),
		.DATA_WIDTH (DATA_BITS)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count >= TIMEOUT_CYCLES) begin
				$display("[indexed_list_engine] ERROR");
				$finish;
			end
		end
	end

	function automatic rsp_item_t apply_request(req_item_t r);
		rsp_item_t o;
		int        pos;
		int        k;
		o.data_out = '0;
		o.status   = ST_OK;
		pos        = r.index;
		if (r.req_type == REQ_INSERT) begin
			if (pos > list_len) begin
				o.status = ST_RANGE;
			end else if (list_len >= LIST_CAP) begin
				o.status = ST_FULL;
			end else begin
				for (k = list_len; k > pos; k--)
					list_words[k] = list_words[k-1];
				list_words[pos] = r.data_in;
				list_len++;
				o.data_out = r.data_in;
			end
		end else if (pos >= list_len) begin
			o.status = ST_RANGE;
		end else if (r.req_type == REQ_GET) begin
			o.data_out = list_words[pos];
		end else if (r.req_type == REQ_REMOVE) begin
			o.data_out = list_words[pos];
			for (k = pos; k + 1 < list_len; k++)
				list_words[k] = list_words[k+1];
			list_len--;
		end else begin
			list_words[pos] = r.data_in;
			o.data_out      = r.data_in;
		end
		o.list_length = LEN_BITS'(list_len);
		return o;
	endfunction

	function automatic req_item_t make_request(req_type_t kind, int pos, logic [31:0] word);
		req_item_t r;
		r.req_type = kind;
		r.index    = INDEX_BITS'(pos);
		r.data_in  = word;
		return r;
	endfunction

	function automatic req_item_t pick_request(int insert_pct, int remove_pct);
		req_item_t r;
		int        roll;
		int        legal_top;
		roll = $urandom_range(99);
		if (roll < insert_pct)
			r.req_type = REQ_INSERT;
		else if (roll < insert_pct + remove_pct)
			r.req_type = REQ_REMOVE;
		else if (roll < insert_pct + remove_pct + (100 - insert_pct - remove_pct) / 2)
			r.req_type = REQ_GET;
		else
			r.req_type = REQ_SET;
		legal_top = (r.req_type == REQ_INSERT) ? list_len : list_len - 1;
		if (legal_top < 0 || $urandom_range(99) < 12)
			r.index = INDEX_BITS'($urandom_range(127));
		else
			r.index = INDEX_BITS'($urandom_range(legal_top));
		case ($urandom_range(9))
			0: r.data_in = '0;
			1: r.data_in = '1;
			default: r.data_in = $urandom;
		endcase
		return r;
	endfunction

	task automatic report_mismatch(string field, logic [31:0] want, logic [31:0] got);
		$display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
		fail_count++;
	endtask

	// Responses are checked before the request of the same edge is predicted; the response
	// is registered, so a transfer never answers a request taken at the same edge.
	always @(posedge clk) begin
		rsp_item_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_rsp.size() == 0) begin
				$display("%0t: unexpected response, expected none, got %h", $time, rsp);
				fail_count++;
			end else begin
				want = pending_rsp.pop_front();
				if (rsp.data_out !== want.data_out)
					report_mismatch("data_out", want.data_out, rsp.data_out);
				if (rsp.status !== want.status)
					report_mismatch("status", 32'(want.status), 32'(rsp.status));
				if (rsp.list_length !== want.list_length)
					report_mismatch("list_length", 32'(want.list_length),
						32'(rsp.list_length));
			end
		end
		if (arst_n && req_valid && req_ready)
			pending_rsp.push_back(apply_request(req));
	end

	initial begin
		rsp_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				rsp_ready <= 1'b0;
				hold_cycles--;
			end else if (receiver_stalls) begin
				rsp_ready <= ($urandom_range(99) >= 36);
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	// Called just after a falling edge; returns just after the falling edge that follows
	// the transfer, so the list model already reflects the request.
	task automatic send_item(req_item_t item);
		if (sender_gaps && $urandom_range(99) < 36) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 2)) @(negedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic test_empty_and_edges();
		send_item(make_request(REQ_GET, 0, 32'h1111_1111));
		send_item(make_request(REQ_REMOVE, 0, 32'h0));
		send_item(make_request(REQ_SET, 0, 32'hDEAD_BEEF));
		send_item(make_request(REQ_INSERT, 1, 32'hCAFE_F00D));
		send_item(make_request(REQ_INSERT, 127, 32'hFFFF_FFFF));
		send_item(make_request(REQ_INSERT, 0, 32'hFFFF_FFFF));
		send_item(make_request(REQ_INSERT, 0, 32'h0000_0000));
		send_item(make_request(REQ_INSERT, 2, 32'hA5A5_A5A5));
		send_item(make_request(REQ_INSERT, 1, 32'h5A5A_5A5A));
		send_item(make_request(REQ_GET, 0, 32'hFFFF_FFFF));
		send_item(make_request(REQ_GET, 3, 32'h0));
		send_item(make_request(REQ_GET, 4, 32'h0));
		send_item(make_request(REQ_GET, 127, 32'h0));
		send_item(make_request(REQ_SET, 3, 32'h1234_5678));
		send_item(make_request(REQ_SET, 4, 32'h8765_4321));
		send_item(make_request(REQ_REMOVE, 1, 32'hFFFF_FFFF));
		send_item(make_request(REQ_REMOVE, 3, 32'h0));
		send_item(make_request(REQ_REMOVE, 0, 32'h0));
		send_item(make_request(REQ_GET, 0, 32'h0));
		send_item(make_request(REQ_REMOVE, 1, 32'h0));
		send_item(make_request(REQ_REMOVE, 0, 32'h0));
		send_item(make_request(REQ_INSERT, 0, 32'h8000_0001));
	endtask

	task automatic test_fill_to_capacity();
		while (list_len < LIST_CAP)
			send_item(make_request(REQ_INSERT, $urandom_range(list_len), $urandom));
		send_item(make_request(REQ_INSERT, LIST_CAP, 32'h0F0F_0F0F));
		send_item(make_request(REQ_INSERT, 0, 32'hF0F0_F0F0));
		send_item(make_request(REQ_INSERT, LIST_CAP + 1, 32'h0));
		send_item(make_request(REQ_INSERT, 127, 32'h0));
		send_item(make_request(REQ_GET, LIST_CAP - 1, 32'h0));
		send_item(make_request(REQ_SET, LIST_CAP - 1, 32'hFFFF_FFFF));
		send_item(make_request(REQ_GET, LIST_CAP, 32'h0));
		send_item(make_request(REQ_REMOVE, LIST_CAP - 1, 32'h0));
		send_item(make_request(REQ_INSERT, LIST_CAP - 1, 32'h7777_7777));
		send_item(make_request(REQ_GET, LIST_CAP - 1, 32'h0));
		send_item(make_request(REQ_REMOVE, 0, 32'h0));
		send_item(make_request(REQ_REMOVE, 0, 32'h0));
	endtask

	task automatic test_output_hold_off();
		@(posedge clk);
		hold_cycles = 150;
		@(negedge clk);
		repeat (16)
			send_item(pick_request(40, 20));
	endtask

	task automatic test_random_traffic();
		int seg;
		int mode;
		for (seg = 0; seg < 21; seg++) begin
			sender_gaps     = !(seg >= 8 && seg <= 10);
			receiver_stalls = !(seg >= 8 && seg <= 10);
			mode            = $urandom_range(2);
			repeat (40) begin
				case (mode)
					0: send_item(pick_request(55, 15));
					1: send_item(pick_request(15, 55));
					default: send_item(pick_request(25, 25));
				endcase
			end
		end
	endtask

	initial begin
		arst_n          = 1'b0;
		req_valid       = 1'b0;
		req             = '0;
		fail_count      = 0;
		list_len        = 0;
		hold_cycles     = 0;
		sender_gaps     = 1'b1;
		receiver_stalls = 1'b1;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		test_empty_and_edges();
		test_fill_to_capacity();
		test_output_hold_off();
		test_random_traffic();

		req_valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
		if (fail_count == 0)
			$display("[indexed_list_engine] OK");
		else
			$display("[indexed_list_engine] ERROR");
		$finish;
	end

endmodule
